[sv/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the stack permutation checker.
// ----------------------------------------------------------------------------
package spc_pkg;

    // Width of a target value and of a push count
    localparam int VAL_W  = 11;
    // Next value to push can reach one past the largest target
    localparam int NP_W   = VAL_W + 1;
    localparam int STAT_W = 2;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [NP_W-1:0]  t_np;

    typedef enum logic [STAT_W-1:0] {
        ST_OK             = 2'd0,
        ST_IMPOSSIBLE     = 2'd1,
        ST_FAILED_EARLIER = 2'd2
    } t_status;

    // One run of consecutive values held on the stack, lo at the bottom
    typedef struct packed {
        t_val lo;
        t_val hi;
    } t_run;

    // Shift control for one cell of the stack chain
    typedef struct packed {
        logic load_up;    // take the run of the neighbor nearer the top
        logic load_down;  // take the run of the neighbor farther from the top
    } t_cell_ctl;

    typedef struct packed {
        t_val    push_count;
        t_status status;
    } t_result;

endpackage

[sv/spc_if.sv]
// ----------------------------------------------------------------------------
// spc_in_if / spc_out_if
// Valid/ready channels carrying target items in and check results out.
// ----------------------------------------------------------------------------
interface spc_in_if import spc_pkg::*; ();
    logic valid;
    logic ready;
    t_val target_value;
    logic start_new;

    modport source(output valid, output target_value, output start_new, input ready);
    modport sink(input valid, input target_value, input start_new, output ready);
endinterface

interface spc_out_if import spc_pkg::*; ();
    logic              valid;
    logic              ready;
    t_val              push_count;
    logic [STAT_W-1:0] status;

    modport source(output valid, output push_count, output status, input ready);
    modport sink(input valid, input push_count, input status, output ready);
endinterface

[sv/stack_permutation_checker.sv]
// ----------------------------------------------------------------------------
// stack_permutation_checker
// Decides whether a target sequence can come out of a stack fed 1, 2, 3, ...
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one target_value per transaction; start_new = 1 begins a new
//   sequence (stack, next push value and failure flag cleared first).
//   o_out returns one result per input transaction, in order: push_count and
//   status (ok, impossible now, failed earlier).
//   Each result is registered before o_out.valid. One item is taken every
//   cycle while i_in.ready is high; each item does a single update of the top
//   stack run, held in cell 0 of a shifting chain of MAX_VALUE/2 run cells.
//   The output side has an output register and a skid slot, so one more item
//   is accepted while a result is stalled; i_in.ready drops only when both
//   are full, and recovers the cycle after o_out.ready returns.
//   Reset (synchronous, active low) empties the stack, sets the next push
//   value to one, clears the failure flag and drops o_out.valid. The cells
//   themselves are not cleared; a run count marks which ones hold data.
// ----------------------------------------------------------------------------
module stack_permutation_checker import spc_pkg::*; #(
    parameter int MAX_VALUE = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spc_in_if.sink     i_in,
    spc_out_if.source  o_out
);

    // Runs are separated by popped values, so at most half the values form runs
    localparam int NUM_CELLS = (MAX_VALUE / 2 > 0) ? MAX_VALUE / 2 : 1;
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_np              r_np;
    t_np              n_np;
    logic             r_failed;
    logic             n_failed;

    t_run      w_run [NUM_CELLS];
    t_cell_ctl w_ctl [NUM_CELLS];
    t_run      w_top_in;

    logic             w_fire;
    logic             w_buf_ready;
    logic [CNT_W-1:0] w_base_cnt;
    t_np              w_base_np;
    logic             w_base_fail;
    t_val             w_tgt;
    t_np              w_tgt_ext;
    logic             w_top_hit;
    logic             w_can_push;
    logic             w_push;
    logic             w_pop;
    logic             w_dec;
    t_result          w_res;
    t_result          w_out_data;

    assign w_fire    = i_in.valid && w_buf_ready;
    assign i_in.ready = w_buf_ready;
    assign w_tgt     = i_in.target_value;
    assign w_tgt_ext = {1'b0, w_tgt};

    always_comb begin
        w_base_cnt  = i_in.start_new ? '0 : r_cnt;
        w_base_np   = i_in.start_new ? NP_W'(1) : r_np;
        w_base_fail = i_in.start_new ? 1'b0 : r_failed;
        w_top_hit   = (w_base_cnt != '0) && (w_run[0].hi == w_tgt);
        w_can_push  = (w_tgt_ext >= w_base_np) && (int'(w_tgt) <= MAX_VALUE);

        n_cnt            = w_base_cnt;
        n_np             = w_base_np;
        n_failed         = w_base_fail;
        w_push           = 1'b0;
        w_pop            = 1'b0;
        w_dec            = 1'b0;
        w_res.push_count = '0;
        w_res.status     = ST_OK;

        if (w_base_fail) begin
            w_res.status = ST_FAILED_EARLIER;
        end else if (w_top_hit) begin
            // Pop the top value: drop a one-value run, else shrink it
            if (w_run[0].lo == w_run[0].hi) begin
                w_pop = 1'b1;
                n_cnt = w_base_cnt - CNT_W'(1);
            end else begin
                w_dec = 1'b1;
            end
        end else if (w_can_push) begin
            w_res.push_count = VAL_W'(w_tgt_ext - w_base_np + NP_W'(1));
            // Values next_push .. target-1 go on as one new run
            if (w_tgt_ext != w_base_np) begin
                w_push = 1'b1;
                n_cnt  = w_base_cnt + CNT_W'(1);
            end
            n_np = w_tgt_ext + NP_W'(1);
        end else begin
            n_failed     = 1'b1;
            w_res.status = ST_IMPOSSIBLE;
        end

        if (w_dec) begin
            w_top_in.lo = w_run[0].lo;
            w_top_in.hi = w_run[0].hi - VAL_W'(1);
        end else begin
            w_top_in.lo = w_base_np[VAL_W-1:0];
            w_top_in.hi = w_tgt - VAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_np     <= NP_W'(1);
            r_failed <= 1'b0;
        end else if (w_fire) begin
            r_cnt    <= n_cnt;
            r_np     <= n_np;
            r_failed <= n_failed;
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        t_run w_up;
        t_run w_down;

        if (g == 0) begin : g_top
            assign w_up = w_top_in;
            assign w_ctl[g].load_up = w_fire && (w_push || w_dec);
        end else begin : g_mid
            assign w_up = w_run[g-1];
            assign w_ctl[g].load_up = w_fire && w_push;
        end

        if (g == NUM_CELLS - 1) begin : g_last
            assign w_down = w_run[g];
        end else begin : g_inner
            assign w_down = w_run[g+1];
        end

        assign w_ctl[g].load_down = w_fire && w_pop;

        spc_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[g]),
            .i_up   (w_up),
            .i_down (w_down),
            .o_run  (w_run[g])
        );
    end

    spc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_buf_ready),
        .i_data  (w_res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_out_data)
    );

    assign o_out.push_count = w_out_data.push_count;
    assign o_out.status     = w_out_data.status;

endmodule

[sv/spc_cell.sv]
// ----------------------------------------------------------------------------
// spc_cell
// One slot of the shifting stack: holds one run of consecutive values.
// ----------------------------------------------------------------------------
module spc_cell import spc_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_run      i_up,
    input  t_run      i_down,
    output t_run      o_run
);

    t_run r_run;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_up) begin
            r_run <= i_up;
        end else if (i_ctl.load_down) begin
            r_run <= i_down;
        end
    end

    assign o_run = r_run;

endmodule

[sv/spc_out_buf.sv]
// ----------------------------------------------------------------------------
// spc_out_buf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module spc_out_buf import spc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    w_in_fire;
    logic    w_out_fire;

    assign o_ready    = !r_skid_valid;
    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_fire) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_in_fire) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

[sv/spc_checker.sv]
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks for the stack permutation checker.
// ----------------------------------------------------------------------------
module spc_checker import spc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_val              i_push_count,
    input logic [STAT_W-1:0] i_status
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_push_count) && $stable(i_status)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_IMPOSSIBLE ||
                         i_status == ST_FAILED_EARLIER))
        else $error("unknown status code");

    a_count_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> (i_push_count == '0))
        else $error("push count on failed item");

    // Input backpressure only when a result is already waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> i_out_valid)
        else $error("result missing one cycle after transaction");

endmodule

bind stack_permutation_checker spc_checker u_spc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_push_count (o_out.push_count),
    .i_status     (o_out.status)
);
